// ===== design/rfd_pkg.sv =====
package rfd_pkg;

	// Queue geometry and cost width.
	localparam int QUEUE_DEPTH = 64;
	localparam int COST_BITS   = 16;

	// Widths of the request and result fields.
	localparam int KIND_W   = 3;
	localparam int TAG_W    = 16;
	localparam int COSTF_W  = 16;
	localparam int TOKEN_W  = 32;
	localparam int DEMAND_W = 22;

	// Derived widths for the queue pointers, the fill count and the exact demand sum.
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DEM_W = CNT_W + COST_BITS;
	localparam int SAT_W = (DEM_W > DEMAND_W) ? DEM_W : DEMAND_W;
	localparam int CMP_W = (DEM_W > TOKEN_W) ? DEM_W : TOKEN_W;

	localparam logic [DEMAND_W-1:0] DEMAND_MAX = {DEMAND_W{1'b1}};
	localparam logic [TOKEN_W-1:0]  BANK_MAX   = {TOKEN_W{1'b1}};

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SAVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TAKE = 3'd4;

	// Status codes.
	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_RETRY = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [TAG_W-1:0]   req_tag;
		logic [COSTF_W-1:0] push_cost;
		logic [TOKEN_W-1:0] token_amount;
	} req_item_t;

	typedef struct packed {
		logic                status;
		logic [TAG_W-1:0]    popped_tag;
		logic [COSTF_W-1:0]  popped_cost;
		logic                head_valid;
		logic [COSTF_W-1:0]  head_cost;
		logic [TOKEN_W-1:0]  tokens_out;
		logic                queue_empty;
		logic [DEMAND_W-1:0] queued_demand;
	} rsp_item_t;

	// One queue entry as it sits in the memory.
	typedef struct packed {
		logic [TAG_W-1:0]     tag;
		logic [COST_BITS-1:0] cost;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Keep the low COST_BITS bits of a request cost.
	function automatic logic [COST_BITS-1:0] trim_cost(input logic [COSTF_W-1:0] c);
		logic [COST_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < COST_BITS; i++) begin
			r[i] = (i < COSTF_W) ? c[i] : 1'b0;
		end
		return r;
	endfunction

	// Bring a stored cost back to the width of the result field.
	function automatic logic [COSTF_W-1:0] fit_cost(input logic [COST_BITS-1:0] c);
		logic [COSTF_W-1:0] r;
		r = '0;
		for (int i = 0; i < COSTF_W; i++) begin
			r[i] = (i < COST_BITS) ? c[i] : 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== design/rfd_req_if.sv =====
interface rfd_req_if;
	import rfd_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== design/rfd_rsp_if.sv =====
interface rfd_rsp_if;
	import rfd_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== design/rfd_ram.sv =====
module rfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port and a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/request_fifo_with_token_demand.sv =====
// A request is captured, the head entry is read while it is held, and the result is registered.
// A new request is not accepted while one is in flight; the registered read of the queue memory
// sets this, since the head entry is read in the cycle of acceptance and used in the next.
// A finished result waits in an output register; the next request is accepted no earlier
// than the cycle in which that result is taken.
// Reset clears the pointers, the fill count, the demand sum and the token bank.
// The queue memory is not cleared; an entry is only used after it was written.
module request_fifo_with_token_demand (
	input  logic     clk,
	input  logic     arst_n,
	rfd_req_if.sink  req,
	rfd_rsp_if.source rsp
);
	import rfd_pkg::*;

	// Queue state.
	logic [IDX_W-1:0]   wr_idx_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [DEM_W-1:0]   demand_q;
	logic [TOKEN_W-1:0] bank_q;

	// Request held while the head entry is read.
	logic                 busy_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [COST_BITS-1:0] cost_s1;
	logic [TOKEN_W-1:0]   offer_s1;

	// Output register.
	logic      out_valid_q;
	rsp_item_t out_q;

	logic   accept;
	logic   ram_we;
	entry_t ram_wdata;
	entry_t head;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               full;
	logic               empty;
	logic [IDX_W-1:0]   wr_idx_next;
	logic [IDX_W-1:0]   rd_idx_next;
	logic [CNT_W-1:0]   count_next;
	logic [DEM_W-1:0]   demand_next;
	logic [TOKEN_W-1:0] bank_next;
	logic [CMP_W-1:0]   demand_cmp;
	logic [CMP_W-1:0]   offer_cmp;
	logic [TOKEN_W-1:0] save_amt;
	logic [TOKEN_W:0]   bank_sum;
	logic [SAT_W-1:0]   demand_sat;
	rsp_item_t          res;

	// Accept only when no request is in flight and the output register frees up.
	assign req.ready = !busy_s1 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

	// Queue storage: tag and cost side by side.
	rfd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign head      = entry_t'(ram_rdata);
	assign ram_wdata = '{tag: tag_s1, cost: cost_s1};
	assign ram_we    = busy_s1 && (kind_s1 == KIND_PUSH) && !full;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign wr_idx_next = (wr_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_next = (rd_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;

	// Amount to bank on a save: the smaller of the offer and the queued demand.
	assign demand_cmp = CMP_W'(demand_q);
	assign offer_cmp  = CMP_W'(offer_s1);
	assign save_amt   = (demand_cmp > offer_cmp) ? offer_s1 : TOKEN_W'(demand_q);
	assign bank_sum   = {1'b0, bank_q} + {1'b0, save_amt};

	// Result and next state for the request in flight.
	always_comb begin
		res         = '0;
		count_next  = count_q;
		demand_next = demand_q;
		bank_next   = bank_q;
		res.status  = STATUS_DONE;
		unique case (kind_s1)
			KIND_PUSH: begin
				if (full) begin
					res.status = STATUS_RETRY;
				end else begin
					count_next  = count_q + 1'b1;
					demand_next = demand_q + DEM_W'(cost_s1);
				end
			end
			KIND_POP: begin
				if (empty) begin
					res.status = STATUS_RETRY;
				end else begin
					res.popped_tag  = head.tag;
					res.popped_cost = fit_cost(head.cost);
					count_next      = count_q - 1'b1;
					demand_next     = (demand_q >= DEM_W'(head.cost)) ?
						demand_q - DEM_W'(head.cost) : '0;
				end
			end
			KIND_PEEK: begin
				if (!empty) begin
					res.head_valid = 1'b1;
					res.head_cost  = fit_cost(head.cost);
				end
			end
			KIND_SAVE: begin
				if (demand_q == '0) begin
					bank_next = '0;
				end else begin
					bank_next      = bank_sum[TOKEN_W] ? BANK_MAX : bank_sum[TOKEN_W-1:0];
					res.tokens_out = save_amt;
				end
			end
			KIND_TAKE: begin
				res.tokens_out = bank_q;
				bank_next      = '0;
			end
			default: begin
			end
		endcase
		res.queue_empty   = (count_next == '0);
		demand_sat        = SAT_W'(demand_next);
		res.queued_demand = (demand_sat > SAT_W'(DEMAND_MAX)) ?
			DEMAND_MAX : demand_sat[DEMAND_W-1:0];
	end

	// Control state and queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			count_q     <= '0;
			demand_q    <= '0;
			bank_q      <= '0;
		end else begin
			busy_s1 <= accept;
			if (busy_s1) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
				demand_q    <= demand_next;
				bank_q      <= bank_next;
				if (ram_we) begin
					wr_idx_q <= wr_idx_next;
				end
				if ((kind_s1 == KIND_POP) && !empty) begin
					rd_idx_q <= rd_idx_next;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req.item.kind;
			tag_s1   <= req.item.req_tag;
			cost_s1  <= trim_cost(req.item.push_cost);
			offer_s1 <= req.item.token_amount;
		end
		if (busy_s1) begin
			out_q <= res;
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import rfd_pkg::*;

	// Operation codes that the block treats as no operation.
	localparam logic [KIND_W-1:0] KIND_NOP_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NOP_LAST  = 3'd7;

	localparam int DIRECTED_ITEMS    = 25;
	localparam int RANDOM_ITEMS      = 1850;
	localparam int SATURATION_AFTER  = 500;
	localparam int SAVES_TO_SATURATE = 1040;
	localparam int HOLD_START        = 300;
	localparam int HOLD_CYCLES       = 400;
	localparam int RESET_CYCLES      = 12;
	localparam int TAIL_CYCLES       = 10;
	localparam int CYCLE_LIMIT       = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rfd_req_if req_ch ();
	rfd_rsp_if rsp_ch ();

	request_fifo_with_token_demand u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests waiting to be offered and results waiting to arrive.
	req_item_t pending_q[$];
	rsp_item_t expected_q[$];

	// Shadow copy of the queue, the demand sum and the token bank.
	logic [TAG_W-1:0]   shadow_tag  [QUEUE_DEPTH];
	logic [COSTF_W-1:0] shadow_cost [QUEUE_DEPTH];
	int unsigned        wr_ptr = 0;
	int unsigned        rd_ptr = 0;
	int unsigned        fill = 0;
	longint unsigned    demand = 0;
	logic [TOKEN_W-1:0] bank = '0;

	// Fill level seen while the stimulus is generated.
	int unsigned gen_level = 0;

	int sent_cnt = 0;
	int phase_len = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_cnt = 0;
	int fail_cnt = 0;
	int checked_cnt = 0;
	int full_retries = 0;
	int empty_retries = 0;
	int saturations = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow state and return the result it must produce.
	function automatic rsp_item_t apply_request(input req_item_t r);
		rsp_item_t       res;
		longint unsigned amt;
		logic [TOKEN_W:0] bank_sum;
		res = '0;
		case (r.kind)
			KIND_PUSH: begin
				if (fill == QUEUE_DEPTH) begin
					res.status = STATUS_RETRY;
					full_retries++;
				end else begin
					shadow_tag[wr_ptr] = r.req_tag;
					shadow_cost[wr_ptr] = r.push_cost;
					wr_ptr = (wr_ptr == QUEUE_DEPTH - 1) ? 0 : wr_ptr + 1;
					fill++;
					demand += r.push_cost;
				end
			end
			KIND_POP: begin
				if (fill == 0) begin
					res.status = STATUS_RETRY;
					empty_retries++;
				end else begin
					res.popped_tag = shadow_tag[rd_ptr];
					res.popped_cost = shadow_cost[rd_ptr];
					demand = (demand >= shadow_cost[rd_ptr]) ? demand - shadow_cost[rd_ptr] : 0;
					rd_ptr = (rd_ptr == QUEUE_DEPTH - 1) ? 0 : rd_ptr + 1;
					fill--;
				end
			end
			KIND_PEEK: begin
				if (fill != 0) begin
					res.head_valid = 1'b1;
					res.head_cost = shadow_cost[rd_ptr];
				end
			end
			KIND_SAVE: begin
				if (demand == 0) begin
					bank = '0;
				end else begin
					amt = (demand > r.token_amount) ? r.token_amount : demand;
					bank_sum = {1'b0, bank} + {1'b0, amt[TOKEN_W-1:0]};
					if (bank_sum[TOKEN_W]) begin
						bank = BANK_MAX;
						saturations++;
					end else begin
						bank = bank_sum[TOKEN_W-1:0];
					end
					res.tokens_out = amt[TOKEN_W-1:0];
				end
			end
			KIND_TAKE: begin
				res.tokens_out = bank;
				bank = '0;
			end
			default: ;
		endcase
		res.queue_empty = (fill == 0);
		res.queued_demand = (demand > DEMAND_MAX) ? DEMAND_MAX : demand[DEMAND_W-1:0];
		return res;
	endfunction

	// Queue one request for the driver and track the fill level it leads to.
	task automatic add_req(input logic [KIND_W-1:0] k, input logic [TAG_W-1:0] t,
			input logic [COSTF_W-1:0] c, input logic [TOKEN_W-1:0] a);
		req_item_t r;
		r.kind = k;
		r.req_tag = t;
		r.push_cost = c;
		r.token_amount = a;
		pending_q.push_back(r);
		if (k == KIND_PUSH && gen_level < QUEUE_DEPTH) begin
			gen_level++;
		end else if (k == KIND_POP && gen_level > 0) begin
			gen_level--;
		end
	endtask

	// Offers are tiny, around the demand range, or, most often, anywhere in 32 bits.
	function automatic logic [TOKEN_W-1:0] rand_offer();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return $urandom_range(32'h003F_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Pacing follows the accepted request count: two idling phases, then none.
	function automatic bit idle_now(input int pct_first, input int pct_second);
		if (sent_cnt < phase_len) begin
			return $urandom_range(99) < pct_first;
		end else if (sent_cnt < 2 * phase_len) begin
			return $urandom_range(99) < pct_second;
		end
		return 1'b0;
	endfunction

	// Report one field of a result against its expected value.
	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Driver: predict each accepted request and offer the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_q.push_back(apply_request(req_ch.item));
				pending_q.pop_front();
				sent_cnt <= sent_cnt + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_q.size() != 0 && !idle_now(29, 60)) begin
					req_ch.valid <= 1'b1;
					req_ch.item <= pending_q[0];
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expected one.
	always @(posedge clk) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("Result arrived with no request outstanding");
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					check_field("status", want.status, rsp_ch.item.status);
					check_field("popped_tag", want.popped_tag, rsp_ch.item.popped_tag);
					check_field("popped_cost", want.popped_cost, rsp_ch.item.popped_cost);
					check_field("head_valid", want.head_valid, rsp_ch.item.head_valid);
					check_field("head_cost", want.head_cost, rsp_ch.item.head_cost);
					check_field("tokens_out", want.tokens_out, rsp_ch.item.tokens_out);
					check_field("queue_empty", want.queue_empty, rsp_ch.item.queue_empty);
					check_field("queued_demand", want.queued_demand,
						rsp_ch.item.queued_demand);
					checked_cnt++;
				end
			end
			rsp_ch.ready <= (hold_left == 0) && !idle_now(60, 29);
		end
	end

	// One long receiver hold-off so that the block backs up onto its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_cnt >= HOLD_START) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("Run exceeded %0d cycles", CYCLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		int ep;
		int cost_cap;
		int w;
		bit saturation_done;
		logic [KIND_W-1:0] k;

		saturation_done = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.item = '0;
		rsp_ch.ready = 1'b0;

		// Directed requests: empty-queue cases, field extremes, every operation.
		add_req(KIND_POP, $urandom, $urandom, $urandom);
		add_req(KIND_PEEK, $urandom, $urandom, $urandom);
		add_req(KIND_SAVE, $urandom, $urandom, '1);
		add_req(KIND_TAKE, $urandom, $urandom, $urandom);
		add_req(KIND_PUSH, '1, '1, '0);
		add_req(KIND_PUSH, '0, '0, '1);
		add_req(KIND_PEEK, '0, '0, '0);
		add_req(KIND_SAVE, '0, '0, '0);
		add_req(KIND_SAVE, '1, '1, 32'd1);
		add_req(KIND_SAVE, '0, '0, '1);
		add_req(KIND_TAKE, '1, '1, '1);
		add_req(KIND_SAVE, $urandom, $urandom, 32'd100);
		add_req(KIND_POP, '1, '1, '1);
		add_req(KIND_PEEK, $urandom, $urandom, $urandom);
		// Only a zero-cost entry is queued, so this save clears the bank.
		add_req(KIND_SAVE, $urandom, $urandom, '1);
		add_req(KIND_TAKE, $urandom, $urandom, $urandom);
		add_req(KIND_POP, $urandom, $urandom, $urandom);
		add_req(KIND_POP, $urandom, $urandom, $urandom);
		add_req(KIND_NOP_FIRST, '1, '1, '1);
		add_req(KIND_NOP_FIRST + 3'd1, $urandom, $urandom, $urandom);
		add_req(KIND_NOP_LAST, '1, '1, '1);
		add_req(KIND_PUSH, $urandom, $urandom, $urandom);
		add_req(KIND_SAVE, $urandom, $urandom, '1);
		add_req(KIND_TAKE, $urandom, $urandom, $urandom);
		add_req(KIND_POP, $urandom, $urandom, $urandom);

		// Random part built from fill, drain and mixed traffic episodes.
		while (pending_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (!saturation_done && pending_q.size() >= SATURATION_AFTER) begin
				// Hold the queue full of maximum costs and save until the bank pins.
				saturation_done = 1'b1;
				while (gen_level != 0) begin
					add_req(KIND_POP, $urandom, $urandom, $urandom);
				end
				repeat (QUEUE_DEPTH) begin
					add_req(KIND_PUSH, $urandom, '1, $urandom);
				end
				add_req(KIND_TAKE, $urandom, $urandom, $urandom);
				repeat (SAVES_TO_SATURATE) begin
					if ($urandom_range(19) == 0) begin
						k = $urandom_range(1) ? KIND_PEEK : KIND_PUSH;
						add_req(k, $urandom, $urandom, $urandom);
					end
					add_req(KIND_SAVE, $urandom, $urandom,
						$urandom_range(32'hFFFF_FFFF, 32'h0040_0000));
				end
				add_req(KIND_TAKE, $urandom, $urandom, $urandom);
				add_req(KIND_SAVE, $urandom, $urandom, '1);
				add_req(KIND_TAKE, $urandom, $urandom, $urandom);
			end
			ep = $urandom_range(3);
			case (ep)
				0: begin
					// Fill to the top, then knock on the full queue a few times.
					n = QUEUE_DEPTH - gen_level + $urandom_range(4, 1);
					repeat (n) begin
						if ($urandom_range(9) < 2) begin
							k = $urandom_range(1) ? KIND_PEEK : KIND_SAVE;
							add_req(k, $urandom, $urandom, rand_offer());
						end
						add_req(KIND_PUSH, $urandom, $urandom, $urandom);
					end
				end
				1: begin
					// Drain to empty, then pop, peek and save on the empty queue.
					n = gen_level + $urandom_range(3, 1);
					repeat (n) begin
						if ($urandom_range(9) < 2) begin
							k = $urandom_range(1) ? KIND_PEEK : KIND_SAVE;
							add_req(k, $urandom, $urandom, rand_offer());
						end
						add_req(KIND_POP, $urandom, $urandom, $urandom);
					end
					add_req(KIND_SAVE, $urandom, $urandom, rand_offer());
				end
				default: begin
					// Mixed traffic; one flavor keeps costs low so offers often exceed demand.
					cost_cap = (ep == 3) ? 40 : 65535;
					n = $urandom_range(60, 20);
					repeat (n) begin
						w = $urandom_range(99);
						if (w < 35) begin
							k = KIND_PUSH;
						end else if (w < 65) begin
							k = KIND_POP;
						end else if (w < 75) begin
							k = KIND_PEEK;
						end else if (w < 87) begin
							k = KIND_SAVE;
						end else if (w < 95) begin
							k = KIND_TAKE;
						end else begin
							k = $urandom_range(KIND_NOP_LAST, KIND_NOP_FIRST);
						end
						add_req(k, $urandom, $urandom_range(cost_cap), rand_offer());
					end
				end
			endcase
		end
		phase_len = pending_q.size() / 3;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results over fill, drain, mixed and bank saturation traffic.",
			checked_cnt);
		$display("Saw %0d full-queue retries, %0d empty-queue retries, %0d saturating saves.",
			full_retries, empty_retries, saturations);
		if (fail_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/rfd_pkg.sv
design/rfd_req_if.sv
design/rfd_rsp_if.sv
design/rfd_ram.sv
design/request_fifo_with_token_demand.sv
tb/tb.sv
